// ----- rtl/unaligned_byte_lane_memory_top_macros.svh -----
// Assertion macros for the unaligned byte lane memory checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef UNALIGNED_BYTE_LANE_MEMORY_TOP_MACROS_SVH
`define UNALIGNED_BYTE_LANE_MEMORY_TOP_MACROS_SVH

// same-cycle implication
`define UBLM_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define UBLM_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- rtl/ublm_pkg.sv -----
// Shared types and codes for the unaligned byte lane memory.
// No dependencies.
package ublm_pkg;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // per-lane placement of the eight bytes of one access
    typedef struct packed {
        logic [7:0]      hi_word;  // lane lands in the second word
        logic [7:0][2:0] offs;     // byte offset inside its word
    } t_lane_map;

endpackage

// ----- rtl/ublm_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ublm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ublm_lane.sv -----
// Address forming: clamps the start and each lane address, finds the two words.
// Depends on ublm_pkg.
module ublm_lane #(
    parameter int MEM_WORDS = 512,
    localparam int WW = $clog2(MEM_WORDS)
) (
    input  logic [15:0]          i_byte_address,
    output logic [WW-1:0]        o_w0,
    output logic [WW-1:0]        o_w1,
    output ublm_pkg::t_lane_map  o_map
);

    localparam logic [16:0] LAST = 17'(8 * MEM_WORDS - 1);

    logic [16:0]   start;
    logic [WW-1:0] w0;

    assign start = ({1'b0, i_byte_address} > LAST) ? LAST : {1'b0, i_byte_address};
    assign w0    = start[WW+2:3];
    assign o_w0  = w0;
    assign o_w1  = (w0 == WW'(MEM_WORDS - 1)) ? '0 : w0 + 1'b1;

    for (genvar i = 0; i < 8; i++) begin : g_lane
        logic [16:0] sum;
        logic [16:0] wrapped;
        logic [16:0] addr;

        assign sum     = start + 17'(i);
        assign wrapped = {1'b0, sum[15:0]};
        assign addr    = (wrapped > LAST) ? LAST : wrapped;

        assign o_map.offs[i]    = addr[2:0];
        assign o_map.hi_word[i] = (addr[WW+2:3] != w0);
    end

endmodule

// ----- rtl/ublm_merge.sv -----
// Byte lane gather for reads and byte merge into both words for writes.
// Depends on ublm_pkg.
module ublm_merge (
    input  logic [63:0]          i_word0,
    input  logic [63:0]          i_word1,
    input  ublm_pkg::t_lane_map  i_map,
    input  logic [63:0]          i_write_data,
    output logic [63:0]          o_read_data,
    output logic [63:0]          o_word0,
    output logic [63:0]          o_word1
);

    always_comb begin
        logic [63:0] src;
        logic [63:0] new0;
        logic [63:0] new1;

        new0        = i_word0;
        new1        = i_word1;
        o_read_data = '0;
        // ascending lanes: a later lane hitting the same byte wins
        for (int i = 0; i < 8; i++) begin
            src = i_map.hi_word[i] ? i_word1 : i_word0;
            o_read_data[8*i +: 8] = src[{i_map.offs[i], 3'b000} +: 8];
            if (i_map.hi_word[i]) begin
                new1[{i_map.offs[i], 3'b000} +: 8] = i_write_data[8*i +: 8];
            end else begin
                new0[{i_map.offs[i], 3'b000} +: 8] = i_write_data[8*i +: 8];
            end
        end
        o_word0 = new0;
        o_word1 = new1;
    end

endmodule

// ----- rtl/unaligned_byte_lane_memory_top.sv -----
// Unaligned byte lane memory, top level: FSM, even/odd word banks, output register.
// Depends on ublm_pkg, ublm_ram, ublm_lane, ublm_merge.
// In the accept cycle of an item both words it may touch are read,
// one from the even-word bank and one from the odd-word bank, each a RAM with a
// registered read; in EXEC the bytes are gathered (read) or merged and written
// back to both banks (write). A read result sits in an output register, so the
// next item is taken while it waits; only when that register is still full and
// not being drained while the next read is in EXEC does the engine hold in EXEC.
// After reset a clearing pass zeroes the banks, one row per cycle over all
// (MEM_WORDS+1)/2 rows of each bank, with o_in_ready low throughout.
module unaligned_byte_lane_memory_top #(
    parameter int MEM_WORDS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [15:0] i_byte_address,
    input  logic [63:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_read_data
);

    localparam int WW         = $clog2(MEM_WORDS);
    localparam int BANK_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    ublm_pkg::t_state    r_state, n_state;
    logic                r_kind;
    logic [63:0]         r_data;
    ublm_pkg::t_lane_map r_map;
    logic                r_w0_odd;
    logic [BAW-1:0]      r_even_addr, r_odd_addr;
    logic [BAW-1:0]      r_clr_addr;
    logic                r_out_valid, n_out_valid;
    logic [63:0]         r_read_data;

    logic                accept;
    logic                ram_re, ram_we, out_load, exec_done, clr_last;
    logic [WW-1:0]       w0, w1;
    ublm_pkg::t_lane_map lane_map;
    logic [BAW-1:0]      even_raddr, odd_raddr, even_waddr, odd_waddr;
    logic [63:0]         even_rdata, odd_rdata, even_wdata, odd_wdata;
    logic [63:0]         word0, word1, new0, new1, gathered;

    ublm_lane #(.MEM_WORDS(MEM_WORDS)) u_lane (
        .i_byte_address (i_byte_address),
        .o_w0           (w0),
        .o_w1           (w1),
        .o_map          (lane_map)
    );

    assign accept     = i_in_valid && o_in_ready;
    assign even_raddr = w0[0] ? BAW'(w1 >> 1) : BAW'(w0 >> 1);
    assign odd_raddr  = w0[0] ? BAW'(w0 >> 1) : BAW'(w1 >> 1);
    assign clr_last   = (r_clr_addr == BAW'(BANK_DEPTH - 1));

    assign word0 = r_w0_odd ? odd_rdata : even_rdata;
    assign word1 = r_w0_odd ? even_rdata : odd_rdata;

    ublm_merge u_merge (
        .i_word0      (word0),
        .i_word1      (word1),
        .i_map        (r_map),
        .i_write_data (r_data),
        .o_read_data  (gathered),
        .o_word0      (new0),
        .o_word1      (new1)
    );

    assign even_wdata = (r_state == ublm_pkg::ST_CLEAR) ? '0 : (r_w0_odd ? new1 : new0);
    assign odd_wdata  = (r_state == ublm_pkg::ST_CLEAR) ? '0 : (r_w0_odd ? new0 : new1);
    assign even_waddr = (r_state == ublm_pkg::ST_CLEAR) ? r_clr_addr : r_even_addr;
    assign odd_waddr  = (r_state == ublm_pkg::ST_CLEAR) ? r_clr_addr : r_odd_addr;

    ublm_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (even_waddr),
        .i_wdata (even_wdata),
        .i_re    (ram_re),
        .i_raddr (even_raddr),
        .o_rdata (even_rdata)
    );

    ublm_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (odd_waddr),
        .i_wdata (odd_wdata),
        .i_re    (ram_re),
        .i_raddr (odd_raddr),
        .o_rdata (odd_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ublm_pkg::ST_CLEAR: begin
                if (clr_last) n_state = ublm_pkg::ST_IDLE;
            end
            ublm_pkg::ST_IDLE: begin
                if (accept) n_state = ublm_pkg::ST_EXEC;
            end
            ublm_pkg::ST_EXEC: begin
                if (exec_done) n_state = ublm_pkg::ST_IDLE;
            end
            default: n_state = ublm_pkg::ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        exec_done  = 1'b0;
        unique case (r_state)
            ublm_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ublm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = i_in_valid;
            end
            ublm_pkg::ST_EXEC: begin
                if (r_kind == ublm_pkg::KIND_WRITE) begin
                    ram_we    = 1'b1;
                    exec_done = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    out_load  = 1'b1;
                    exec_done = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ublm_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ublm_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_kind;
            r_data      <= i_write_data;
            r_map       <= lane_map;
            r_w0_odd    <= w0[0];
            r_even_addr <= even_raddr;
            r_odd_addr  <= odd_raddr;
        end
        if (out_load) begin
            r_read_data <= gathered;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

// ----- rtl/ublm_checker.sv -----
// Port-level checker for the unaligned byte lane memory, bound to the top level.
// Depends on ublm_pkg and unaligned_byte_lane_memory_top_macros.svh.
`include "unaligned_byte_lane_memory_top_macros.svh"

module ublm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_kind,
    input logic        o_out_valid,
    input logic        i_out_ready
);

    logic in_acc;
    logic rd_acc;
    logic wr_acc;

    assign in_acc = i_in_valid && o_in_ready;
    assign rd_acc = in_acc && (i_kind == ublm_pkg::KIND_READ) && !o_out_valid;
    assign wr_acc = in_acc && (i_kind == ublm_pkg::KIND_WRITE) && !o_out_valid;

    `UBLM_CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result word dropped")
    `UBLM_CHK_NEXT(a_busy_after_accept, in_acc, !o_in_ready, "word accepted while busy")
    `UBLM_CHK_NEXT(a_write_silent, wr_acc, !o_out_valid, "write word produced a result")
    `UBLM_CHK_NOW(a_read_latency, rd_acc, ##2 o_out_valid, "read result late")

endmodule

bind unaligned_byte_lane_memory_top ublm_checker u_ublm_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for unaligned_byte_lane_memory_top: directed and random eight-byte reads and
// writes, with each read checked against a byte-level image of the store kept in the bench.
// Depends on ublm_pkg and the unaligned_byte_lane_memory_top RTL.
module tb;

    localparam int MEM_WORDS       = 512;
    localparam int LAST_BYTE       = MEM_WORDS * 8 - 1;
    localparam int IDLE_LIMIT      = 3000;
    localparam int ITEMS_PER_PHASE = 470;
    localparam int EXP_DEPTH       = 16;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_kind         = ublm_pkg::KIND_READ;
    logic [15:0] i_byte_address = '0;
    logic [63:0] i_write_data   = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_read_data;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int quiet_cycles       = 0;

    logic [63:0] mem_image [MEM_WORDS];
    logic [63:0] exp_reads [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;

    unaligned_byte_lane_memory_top #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_byte_address(i_byte_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic int lane_address(int start, int lane);
        int a;
        a = (start + lane) & 16'hFFFF;
        return (a > LAST_BYTE) ? LAST_BYTE : a;
    endfunction

    function automatic logic [63:0] load_bytes(logic [15:0] addr);
        int          start;
        int          a;
        int          i;
        logic [63:0] v;
        start = (int'(addr) > LAST_BYTE) ? LAST_BYTE : int'(addr);
        v = '0;
        for (i = 0; i < 8; i++) begin
            a = lane_address(start, i);
            v[i*8 +: 8] = mem_image[(a >> 3) % MEM_WORDS][(a % 8) * 8 +: 8];
        end
        return v;
    endfunction

    task automatic store_bytes(logic [15:0] addr, logic [63:0] data);
        int start;
        int a;
        int i;
        start = (int'(addr) > LAST_BYTE) ? LAST_BYTE : int'(addr);
        for (i = 0; i < 8; i++) begin
            a = lane_address(start, i);
            mem_image[(a >> 3) % MEM_WORDS][(a % 8) * 8 +: 8] = data[i*8 +: 8];
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // called and returns at a falling edge
    task automatic send_word(logic kind, logic [15:0] addr, logic [63:0] data);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_byte_address <= addr;
        i_write_data   <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (kind == ublm_pkg::KIND_WRITE) begin
            store_bytes(addr, data);
        end else begin
            exp_reads[exp_wr % EXP_DEPTH] = load_bytes(addr);
            exp_wr++;
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_reads
        logic [63:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch($sformatf("unexpected word, read_data %h", o_read_data));
            end else begin
                want = exp_reads[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_read_data !== want) begin
                    report_mismatch($sformatf("read_data %h, expected %h", o_read_data, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_aligned_words();
        send_word(ublm_pkg::KIND_READ,  16'd16,   64'hDEAD_BEEF_0BAD_F00D);
        send_word(ublm_pkg::KIND_WRITE, 16'd0,    64'h0706_0504_0302_0100);
        send_word(ublm_pkg::KIND_WRITE, 16'd8,    64'hFFFF_FFFF_FFFF_FFFF);
        send_word(ublm_pkg::KIND_READ,  16'd0,    64'h0);
        send_word(ublm_pkg::KIND_READ,  16'd8,    64'h0);
        send_word(ublm_pkg::KIND_WRITE, 16'd4088, 64'h8877_6655_4433_2211);
        send_word(ublm_pkg::KIND_READ,  16'd4088, 64'h0);
    endtask

    task automatic test_unaligned_offsets();
        int off;
        send_word(ublm_pkg::KIND_WRITE, 16'd13, 64'hA1B2_C3D4_E5F6_0718);
        for (off = 1; off < 8; off++) begin
            send_word(ublm_pkg::KIND_READ, 16'(8 + off), 64'h0);
        end
    endtask

    task automatic test_end_of_memory();
        // running past the last byte, start at the last byte, start beyond memory
        send_word(ublm_pkg::KIND_WRITE, 16'd4090,  64'h1122_3344_5566_7788);
        send_word(ublm_pkg::KIND_READ,  16'd4090,  64'h0);
        send_word(ublm_pkg::KIND_READ,  16'd4095,  64'h0);
        send_word(ublm_pkg::KIND_WRITE, 16'd4095,  64'hC0FF_EE00_1234_5678);
        send_word(ublm_pkg::KIND_READ,  16'd4088,  64'h0);
        send_word(ublm_pkg::KIND_WRITE, 16'd5000,  64'h5A5A_5A5A_5A5A_5AA5);
        send_word(ublm_pkg::KIND_READ,  16'd65535, 64'h0);
        send_word(ublm_pkg::KIND_READ,  16'd4096,  64'h0);
        send_word(ublm_pkg::KIND_WRITE, 16'd65528, 64'h0F1E_2D3C_4B5A_6978);
        send_word(ublm_pkg::KIND_READ,  16'd4092,  64'h0);
        send_word(ublm_pkg::KIND_WRITE, 16'd4087,  64'h0000_0000_0000_0000);
        send_word(ublm_pkg::KIND_READ,  16'd4087,  64'h0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
        int          n;
        int          r;
        logic [15:0] addr;
        logic        kind;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                addr = 16'($urandom_range(0, 127));
            end else if (r < 65) begin
                addr = 16'($urandom_range(LAST_BYTE - 40, LAST_BYTE));
            end else if (r < 85) begin
                addr = 16'($urandom_range(0, LAST_BYTE));
            end else begin
                addr = 16'($urandom_range(0, 65535));
            end
            kind = ($urandom_range(0, 1) == 1) ? ublm_pkg::KIND_WRITE : ublm_pkg::KIND_READ;
            send_word(kind, addr, {$urandom, $urandom});
        end
    endtask

    initial begin
        foreach (mem_image[w]) mem_image[w] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_aligned_words();
        test_unaligned_offsets();
        test_end_of_memory();
        test_random_traffic(0,  0,  ITEMS_PER_PHASE);
        test_random_traffic(77, 0,  ITEMS_PER_PHASE);
        test_random_traffic(0,  77, ITEMS_PER_PHASE);
        test_random_traffic(22, 22, ITEMS_PER_PHASE);

        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- unaligned_byte_lane_memory_top.f -----
+incdir+rtl
rtl/ublm_pkg.sv
rtl/ublm_ram.sv
rtl/ublm_lane.sv
rtl/ublm_merge.sv
rtl/unaligned_byte_lane_memory_top.sv
rtl/ublm_checker.sv
sim/tb.sv
